// File: rtl/core/cfws_pkg.sv
// ----------------------------------------------------------------------------
// cfws_pkg
// Shared types and constants of the circular FIFO with search.
// ----------------------------------------------------------------------------
package cfws_pkg;

    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_SRCH = 2'd2,
        OP_DUMP = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_OVF   = 3'd1,
        ST_DEQ   = 3'd2,
        ST_UNF   = 3'd3,
        ST_FOUND = 3'd4,
        ST_MISS  = 3'd5,
        ST_DUMP  = 3'd6,
        ST_END   = 3'd7
    } t_status;

    typedef struct packed {
        t_status status;
        logic    last;
    } t_result;

endpackage

// File: rtl/core/cfws_mem.sv
// ----------------------------------------------------------------------------
// cfws_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfws_mem #(
    parameter int DEPTH = 16,
    parameter int PW    = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [PW-1:0]              i_waddr,
    input  logic [cfws_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [PW-1:0]              i_raddr,
    output logic [cfws_pkg::DATA_W-1:0] o_rdata
);
    import cfws_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cfws_seq.sv
// ----------------------------------------------------------------------------
// cfws_seq
// Command sequencer: queue pointers, fill count and the entry scan loop.
// ----------------------------------------------------------------------------
module cfws_seq #(
    parameter int DEPTH = 16,
    parameter int PW    = 4,
    parameter int CW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  cfws_pkg::t_opcode           i_cmd_op,
    input  logic [cfws_pkg::DATA_W-1:0] i_cmd_value,
    input  logic [CW-1:0]               i_cap,
    output logic                        o_mem_we,
    output logic [PW-1:0]               o_mem_waddr,
    output logic [cfws_pkg::DATA_W-1:0] o_mem_wdata,
    output logic                        o_mem_re,
    output logic [PW-1:0]               o_mem_raddr,
    input  logic [cfws_pkg::DATA_W-1:0] i_mem_rdata,
    input  logic                        i_out_free,
    output logic                        o_res_load,
    output cfws_pkg::t_result           o_res,
    output logic [cfws_pkg::DATA_W-1:0] o_res_data
);
    import cfws_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ONE       = CW'(1);

    t_state            r_state, n_state;
    logic [PW-1:0]     r_rp, n_rp;
    logic [PW-1:0]     r_wp, n_wp;
    logic [CW-1:0]     r_fill, n_fill;
    logic [PW-1:0]     r_scan, n_scan;
    logic [CW-1:0]     r_left, n_left;
    t_opcode           r_op, n_op;
    logic [DATA_W-1:0] r_key, n_key;
    t_status           r_st, n_st;

    logic [PW-1:0]     rp_inc, wp_inc, scan_inc;
    logic              key_hit;
    logic              done_has_key;

    assign rp_inc   = (r_rp == LAST_SLOT)   ? '0 : r_rp + PW'(1);
    assign wp_inc   = (r_wp == LAST_SLOT)   ? '0 : r_wp + PW'(1);
    assign scan_inc = (r_scan == LAST_SLOT) ? '0 : r_scan + PW'(1);
    assign key_hit  = (i_mem_rdata == r_key);

    assign done_has_key = (r_st == ST_ENQ) || (r_st == ST_FOUND) || (r_st == ST_MISS);

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_mem_waddr = r_wp;
    assign o_mem_wdata = i_cmd_value;
    assign o_mem_re    = (r_state == S_READ);
    assign o_mem_raddr = r_scan;
    assign o_res_data  = (r_state == S_CHECK) ? i_mem_rdata :
                         (done_has_key ? r_key : '0);

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_scan     = r_scan;
        n_left     = r_left;
        n_op       = r_op;
        n_key      = r_key;
        n_st       = r_st;
        o_mem_we   = 1'b0;
        o_res_load = 1'b0;
        o_res      = '{status: r_st, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_op   = i_cmd_op;
                    n_key  = i_cmd_value;
                    n_scan = r_rp;
                    n_left = r_fill;
                    case (i_cmd_op)
                        OP_ENQ: begin
                            n_state = S_DONE;
                            if (r_fill >= i_cap) begin
                                n_st = ST_OVF;
                            end else begin
                                n_st     = ST_ENQ;
                                o_mem_we = 1'b1;
                                n_wp     = wp_inc;
                                n_fill   = r_fill + ONE;
                            end
                        end
                        OP_DEQ: begin
                            if (r_fill == '0) begin
                                n_st    = ST_UNF;
                                n_state = S_DONE;
                            end else begin
                                n_rp    = rp_inc;
                                n_fill  = r_fill - ONE;
                                n_state = S_READ;
                            end
                        end
                        OP_SRCH: begin
                            if (r_fill == '0) begin
                                n_st    = ST_MISS;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            if (r_fill == '0) begin
                                n_st    = ST_END;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                case (r_op)
                    OP_DEQ: begin
                        if (i_out_free) begin
                            o_res_load = 1'b1;
                            o_res      = '{status: ST_DEQ, last: 1'b1};
                            n_state    = S_IDLE;
                        end
                    end
                    OP_SRCH: begin
                        if (key_hit) begin
                            n_st    = ST_FOUND;
                            n_state = S_DONE;
                        end else if (r_left == ONE) begin
                            n_st    = ST_MISS;
                            n_state = S_DONE;
                        end else begin
                            n_scan  = scan_inc;
                            n_left  = r_left - ONE;
                            n_state = S_READ;
                        end
                    end
                    OP_DUMP: begin
                        if (i_out_free) begin
                            o_res_load = 1'b1;
                            o_res      = '{status: ST_DUMP, last: 1'b0};
                            if (r_left == ONE) begin
                                n_st    = ST_END;
                                n_state = S_DONE;
                            end else begin
                                n_scan  = scan_inc;
                                n_left  = r_left - ONE;
                                n_state = S_READ;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_left <= n_left;
        r_op   <= n_op;
        r_key  <= n_key;
        r_st   <= n_st;
    end

    logic [PW:0] ptr_gap;
    logic [CW-1:0] fill_wrapped;

    assign ptr_gap      = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                         : ({1'b0, r_wp} + (PW+1)'(DEPTH) - {1'b0, r_rp});
    assign fill_wrapped = (r_fill == CW'(DEPTH)) ? '0 : r_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= DEPTH)
        else $error("fill count exceeds the queue depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(ptr_gap) == int'(fill_wrapped))
        else $error("pointer distance disagrees with the fill count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_out_free)
        else $error("result loaded while the output register is occupied");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CHECK) |-> (r_left != '0))
        else $error("scan running with no entries left");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |=> (r_fill != '0) && (int'(r_fill) <= DEPTH))
        else $error("enqueue wrote past the queue depth");

endmodule

// File: rtl/core/circular_fifo_with_search.sv
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Bounded circular FIFO of signed 64-bit values with enqueue, dequeue, search
// and dump commands.
// ----------------------------------------------------------------------------
// The block takes one command at a time and is not ready while it works on it.
// Enqueue, overflow, underflow and any command on an empty queue go straight to
// the done state, and a dequeue first reads its entry. Search and dump read and
// check each entry they visit in turn; the pace is set by the single
// read port of the entry memory, whose read data is registered. A result goes
// into an output register, so the next command is taken while it waits.
module circular_fifo_with_search #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,     // capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // value
    input  logic [1:0]  s_axis_tuser,    // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,    // data
    output logic [2:0]  m_axis_tuser,    // status
    output logic        m_axis_tlast
);
    import cfws_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0]  r_capacity;
    logic [CW-1:0]     cap_eff;
    logic              r_out_valid;
    t_result           r_out;
    logic [DATA_W-1:0] r_out_data;
    logic              out_free;

    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              res_load;
    t_result           res;
    logic [DATA_W-1:0] res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign cap_eff = (r_capacity == '0)        ? CW'(1) :
                     (int'(r_capacity) > DEPTH) ? CW'(DEPTH) : CW'(r_capacity);

    assign out_free = !r_out_valid || m_axis_tready;

    cfws_mem #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cfws_seq #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd_op    (t_opcode'(s_axis_tuser)),
        .i_cmd_value (s_axis_tdata),
        .i_cap       (cap_eff),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_res_data  (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out      <= res;
            r_out_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the circular FIFO with search. It sends
// enqueue, dequeue, search and dump commands over the input stream. A
// predictor inside the testbench tracks the queue contents and works out
// every result in order. Each output transfer is checked against it field by
// field. Both stream sides idle and stall at random, and the capacity
// register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
    import cfws_pkg::*;

    localparam int DEPTH        = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int PHASE_ITEMS  = 48;

    typedef struct {
        t_status     status;
        logic [63:0] data;
        logic        last;
    } t_fifo_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [4:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [63:0] queue_slots [DEPTH];
    logic [3:0]  head_slot    = '0;
    logic [3:0]  tail_slot    = '0;
    int unsigned queue_fill   = 0;
    logic [4:0]  capacity_reg = CAP_RESET;

    t_fifo_result pending_results [$];
    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int dump_entries = 0;
    int cfg_writes   = 0;
    bit quiet        = 1'b0;

    circular_fifo_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned active_capacity();
        int unsigned cap;
        cap = 32'(capacity_reg);
        if (cap == 0) return 1;
        if (cap > DEPTH) return DEPTH;
        return cap;
    endfunction

    function automatic void push_result(t_status st, logic [63:0] d, logic l);
        t_fifo_result r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_command(t_opcode op, logic [63:0] val);
        logic [3:0] p;
        bit         hit;
        p   = head_slot;
        hit = 1'b0;
        case (op)
            OP_ENQ: begin
                if (queue_fill >= active_capacity()) begin
                    push_result(ST_OVF, '0, 1'b1);
                end else begin
                    queue_slots[tail_slot] = val;
                    tail_slot = tail_slot + 4'd1;
                    queue_fill++;
                    push_result(ST_ENQ, val, 1'b1);
                end
            end
            OP_DEQ: begin
                if (queue_fill == 0) begin
                    push_result(ST_UNF, '0, 1'b1);
                end else begin
                    push_result(ST_DEQ, queue_slots[head_slot], 1'b1);
                    head_slot = head_slot + 4'd1;
                    queue_fill--;
                end
            end
            OP_SRCH: begin
                for (int i = 0; i < queue_fill && !hit; i++) begin
                    if (queue_slots[p] == val) hit = 1'b1;
                    p = p + 4'd1;
                end
                push_result(hit ? ST_FOUND : ST_MISS, val, 1'b1);
            end
            default: begin
                for (int i = 0; i < queue_fill; i++) begin
                    push_result(ST_DUMP, queue_slots[p], 1'b0);
                    p = p + 4'd1;
                end
                push_result(ST_END, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       return 64'h8000_0000_0000_0000;
                1:       return 64'h7FFF_FFFF_FFFF_FFFF;
                2:       return 64'h0;
                default: return '1;
            endcase
        end
        if (r < 35) return 64'($urandom_range(0, 7));
        return {$urandom, $urandom};
    endfunction

    task automatic send_command(t_opcode op, logic [63:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_command(op, val);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg  = v;
        cfg_writes++;
    endtask

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic test_empty_queue();
        send_command(OP_DEQ, '1);
        send_command(OP_DUMP, 64'h5555_5555_5555_5555);
        send_command(OP_SRCH, 64'h0);
    endtask

    task automatic test_full_queue();
        logic [63:0] seed_values [8];
        seed_values = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, '1,
                        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1, 64'h1};
        foreach (seed_values[i]) send_command(OP_ENQ, seed_values[i]);
        repeat (DEPTH - 8) send_command(OP_ENQ, {$urandom, $urandom});
        send_command(OP_ENQ, 64'h1234_5678_9ABC_DEF0);
        send_command(OP_SRCH, 64'h1);
        send_command(OP_SRCH, 64'h2);
        send_command(OP_DUMP, '0);
    endtask

    task automatic test_shrunk_capacity();
        write_capacity(5'd4);
        send_command(OP_ENQ, 64'h0F0F_0F0F_0F0F_0F0F);
        send_command(OP_DEQ, '0);
        send_command(OP_SRCH, queue_slots[tail_slot - 4'd1]);
    endtask

    task automatic test_random_traffic();
        logic [4:0]  phase_caps [8];
        logic [63:0] val;
        logic [3:0]  idx;
        t_opcode     op;
        int          r;
        phase_caps = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd3, 5'd16, 5'd8, 5'd0};
        phase_caps[7] = 5'($urandom_range(0, 31));
        foreach (phase_caps[ph]) begin
            write_capacity(phase_caps[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 12 == 0) quiet = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    op  = OP_ENQ;
                    val = pick_value();
                end else if (r < 70) begin
                    op  = OP_DEQ;
                    val = {$urandom, $urandom};
                end else if (r < 90) begin
                    op = OP_SRCH;
                    if (queue_fill > 0 && $urandom_range(0, 1) == 1) begin
                        idx = head_slot + 4'($urandom_range(0, queue_fill - 1));
                        val = queue_slots[idx];
                    end else begin
                        val = pick_value();
                    end
                end else begin
                    op  = OP_DUMP;
                    val = {$urandom, $urandom};
                end
                send_command(op, val);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        int run_len;
        run_len = 0;
        forever begin
            @(posedge i_clk);
            if (run_len > 0) begin
                run_len--;
            end else if (quiet) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 65) begin
                m_axis_tready <= 1'b1;
                run_len = $urandom_range(0, 7);
            end else begin
                m_axis_tready <= 1'b0;
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result status=%0d data=%h last=%b",
                                     m_axis_tuser, m_axis_tdata, m_axis_tlast));
            end else begin
                want = pending_results.pop_front();
                if (want.status == ST_DUMP) dump_entries++;
                if (m_axis_tuser !== want.status || m_axis_tdata !== want.data ||
                    m_axis_tlast !== want.last) begin
                    note_error($sformatf(
                        "expected status=%s data=%h last=%b, got status=%0d data=%h last=%b",
                        want.status.name(), want.data, want.last,
                        m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_full_queue();
        test_shrunk_capacity();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d commands and checked %0d results, %0d of them dumped entries.",
                 items_sent, results_seen, dump_entries);
        $display("The capacity register took %0d settings, including 0, 1, 16, 17 and 31.",
                 cfg_writes);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results never arrived.", errors,
                     pending_results.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/cfws_pkg.sv
rtl/core/cfws_mem.sv
rtl/core/cfws_seq.sv
rtl/core/circular_fifo_with_search.sv
tb/tb.sv
